// ----- rtl/bfns_pkg.sv -----
// Shared types, constants and helper functions for the bitmap find-next-set block.
// No dependencies; every other file uses this package.
package bfns_pkg;

  localparam int FUNC_W    = 3;
  localparam int POS_W     = 9;
  localparam int FPOS_W    = 8;
  localparam int CNT_W     = 9;
  localparam int WORD_BITS = 64;
  localparam int BIT_SEL_W = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_SET         = 3'd0,
    FN_TEST        = 3'd1,
    FN_FIND_FIRST  = 3'd2,
    FN_FIND_AFTER  = 3'd3,
    FN_SET_FIRST_N = 3'd4,
    FN_CLEAR       = 3'd5
  } bfns_func_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } bfns_store_ctl_t;

  // Index of the lowest set bit of a word; 0 when the word is empty.
  function automatic logic [BIT_SEL_W-1:0] lowest_set(input logic [WORD_BITS-1:0] word);
    logic [BIT_SEL_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = BIT_SEL_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/bfns_cmd_if.sv -----
// Command channel: valid/ready handshake carrying func and position.
// Depends on bfns_pkg for field widths.
interface bfns_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [bfns_pkg::FUNC_W-1:0]   func;
  logic [bfns_pkg::POS_W-1:0]    position;

  modport source(output valid, func, position, input ready);
  modport sink(input valid, func, position, output ready);
endinterface

// ----- rtl/bfns_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result per command.
// Depends on bfns_pkg for field widths.
interface bfns_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          bit_is_set;
  logic                          found;
  logic [bfns_pkg::FPOS_W-1:0]   found_position;
  logic [bfns_pkg::CNT_W-1:0]    set_total;

  modport source(output valid, bit_is_set, found, found_position, set_total, input ready);
  modport sink(input valid, bit_is_set, found, found_position, set_total, output ready);
endinterface

// ----- rtl/bitmap_find_next_set_top.sv -----
// Bitmap of NUM_BITS bits with a running count of set bits, driven one command at a
// time: set, test, find first, find after position, set first n, clear. One command is
// in flight at a time; the bitmap lives in a single-port word memory, and every word
// access goes through a read-issue state, then a use/write-back state. Set and test of
// an in-range bit access one word; out-of-range ones, clear and unused codes access
// none; a find scans k words (at most NUM_BITS/64, and 0 when the start lies past the
// end); set-first-n visits all NUM_BITS/64 words.
// A new command is accepted while the previous result still waits in the output
// register. No clearing pass after reset is needed. Depends on bfns_pkg, bfns_cmd_if,
// bfns_rsp_if and bfns_word_store.
module bitmap_find_next_set_top #(
  parameter int NUM_BITS = 256
) (
  input  logic          clk,
  input  logic          rst,
  bfns_cmd_if.sink      cmd,
  bfns_rsp_if.source    rsp
);
  import bfns_pkg::*;

  localparam int WORD_COUNT = NUM_BITS / WORD_BITS;
  localparam int WIDX = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int AW = ($clog2(NUM_BITS) + 1 > POS_W + 1) ? $clog2(NUM_BITS) + 1 : POS_W + 1;
  localparam int NW = AW - BIT_SEL_W;
  localparam logic [AW-1:0]   LIMIT     = AW'(NUM_BITS);
  localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORD_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_USE,
    S_DONE
  } state_t;

  state_t              state;
  logic [FUNC_W-1:0]   func_q;
  logic [AW-1:0]       arg;
  logic [WIDX-1:0]     wptr;
  logic                first_word;
  logic                res_is_set;
  logic                res_found;
  logic [FPOS_W-1:0]   res_fpos;
  logic [CNT_W-1:0]    count;

  bfns_store_ctl_t       store_ctl;
  logic [WORD_BITS-1:0]  rd_word;
  logic [WORD_BITS-1:0]  wr_word;
  logic                  accept;
  logic                  load;
  logic [AW-1:0]         pos_ext;
  logic [AW-1:0]         start;
  logic [AW-1:0]         n_sat;
  logic [BIT_SEL_W-1:0]  bit_sel;
  logic                  cur_bit;
  logic [WORD_BITS-1:0]  masked;
  logic [WORD_BITS-1:0]  fill;
  logic [NW-1:0]         n_word;
  logic [NW-1:0]         wptr_ext;
  logic [BIT_SEL_W-1:0]  enc;
  logic [WIDX+BIT_SEL_W:0] gidx;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign load      = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    pos_ext  = AW'(cmd.position);
    start    = (cmd.func == FN_FIND_FIRST) ? '0 : pos_ext + AW'(1);
    n_sat    = (pos_ext > LIMIT) ? LIMIT : pos_ext;
    bit_sel  = arg[BIT_SEL_W-1:0];
    cur_bit  = rd_word[bit_sel];
    masked   = first_word ? (rd_word & ({WORD_BITS{1'b1}} << bit_sel)) : rd_word;
    enc      = lowest_set(masked);
    gidx     = {1'b0, wptr, enc};
    n_word   = arg[AW-1:BIT_SEL_W];
    wptr_ext = NW'(wptr);
    if (n_word > wptr_ext) begin
      fill = {WORD_BITS{1'b1}};
    end else if (n_word == wptr_ext) begin
      fill = ~({WORD_BITS{1'b1}} << bit_sel);
    end else begin
      fill = '0;
    end
    wr_word = (func_q == FN_SET) ? (rd_word | (WORD_BITS'(1) << bit_sel)) : (rd_word | fill);
    store_ctl.rd_en = (state == S_READ);
    store_ctl.wr_en = (state == S_USE) &&
                      (((func_q == FN_SET) && !cur_bit) || (func_q == FN_SET_FIRST_N));
    store_ctl.clear = accept && (cmd.func == FN_CLEAR);
  end

  bfns_word_store #(
    .WORDS (WORD_COUNT),
    .IDX_W (WIDX)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .addr    (wptr),
    .wr_data (wr_word),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rsp.valid  <= 1'b0;
      func_q     <= '0;
      first_word <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !load) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_q     <= cmd.func;
            res_is_set <= 1'b0;
            res_found  <= 1'b0;
            res_fpos   <= '0;
            first_word <= 1'b1;
            case (cmd.func)
              FN_SET, FN_TEST: begin
                arg  <= pos_ext;
                wptr <= pos_ext[BIT_SEL_W +: WIDX];
                state <= (pos_ext < LIMIT) ? S_READ : S_DONE;
              end
              FN_FIND_FIRST, FN_FIND_AFTER: begin
                arg  <= start;
                wptr <= start[BIT_SEL_W +: WIDX];
                state <= (start < LIMIT) ? S_READ : S_DONE;
              end
              FN_SET_FIRST_N: begin
                arg   <= n_sat;
                wptr  <= '0;
                state <= S_READ;
              end
              FN_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_USE;
        end
        S_USE: begin
          first_word <= 1'b0;
          case (func_q)
            FN_SET: begin
              if (!cur_bit && (count != CNT_MAX)) begin
                count <= count + CNT_W'(1);
              end
              state <= S_DONE;
            end
            FN_TEST: begin
              res_is_set <= cur_bit;
              state      <= S_DONE;
            end
            FN_FIND_FIRST, FN_FIND_AFTER: begin
              if (masked != '0) begin
                res_found <= 1'b1;
                res_fpos  <= gidx[FPOS_W-1:0];
                state     <= S_DONE;
              end else if (wptr == LAST_WORD) begin
                state <= S_DONE;
              end else begin
                wptr  <= wptr + WIDX'(1);
                state <= S_READ;
              end
            end
            FN_SET_FIRST_N: begin
              if (wptr == LAST_WORD) begin
                count <= (arg > AW'(CNT_MAX)) ? CNT_MAX : arg[CNT_W-1:0];
                state <= S_DONE;
              end else begin
                wptr  <= wptr + WIDX'(1);
                state <= S_READ;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          // Hold the result until the output register frees up.
          if (load) begin
            rsp.valid          <= 1'b1;
            rsp.bit_is_set     <= res_is_set;
            rsp.found          <= res_found;
            rsp.found_position <= res_fpos;
            rsp.set_total      <= count;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_wptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_USE) |-> (wptr <= LAST_WORD))
    else $error("word pointer beyond last word");

  a_clear_zero_total: assert property (@(posedge clk) disable iff (rst)
    (load && (func_q == FN_CLEAR)) |=> (rsp.set_total == '0))
    else $error("clear did not report an empty count");

  a_is_set_only_test: assert property (@(posedge clk) disable iff (rst)
    (load && res_is_set) |-> (func_q == FN_TEST))
    else $error("bit_is_set raised for a non-test command");

  a_found_only_find: assert property (@(posedge clk) disable iff (rst)
    (load && res_found) |-> ((func_q == FN_FIND_FIRST) || (func_q == FN_FIND_AFTER)))
    else $error("found raised for a non-find command");
`endif

endmodule

// ----- rtl/bfns_word_store.sv -----
// Word memory of the bitmap: one shared read/write address, registered read,
// and a valid bit per word so that reset and clear empty it at once. Uses bfns_pkg.
module bfns_word_store #(
  parameter int WORDS = 4,
  parameter int IDX_W = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bfns_pkg::bfns_store_ctl_t         ctl,
  input  logic [IDX_W-1:0]                  addr,
  input  logic [bfns_pkg::WORD_BITS-1:0]    wr_data,
  output logic [bfns_pkg::WORD_BITS-1:0]    rd_data
);
  import bfns_pkg::*;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     word_valid;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_ok      <= 1'b0;
    end else begin
      if (ctl.clear) begin
        word_valid <= '0;
      end else if (ctl.wr_en) begin
        word_valid[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_ok <= word_valid[addr];
      end
    end
  end

  // A word never written since reset or clear reads as zero.
  assign rd_data = rd_ok ? rd_q : '0;

endmodule
